@@ sv/ckv_pkg.sv @@
// Shared types and constants of the compacting key/value table.
package ckv_pkg;

    // Widths of the fixed request and result fields.
    localparam int KEY_W       = 64;
    localparam int KLEN_W      = 4;
    localparam int PAY_W       = 64;
    localparam int PLEN_W      = 4;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 5;
    localparam int S_TDATA_W   = KEY_W + KLEN_W + PAY_W + PLEN_W;
    localparam int M_TDATA_W   = STATUS_W + COUNT_OUT_W;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int CAP_W      = 5;
    localparam int LEN_CFG_W  = 4;

    typedef logic [CFG_IDX_W-1:0] ckv_cfg_idx_t;
    localparam ckv_cfg_idx_t CFG_CAPACITY_LIMIT     = 2'd0;
    localparam ckv_cfg_idx_t CFG_MAX_KEY_LENGTH     = 2'd1;
    localparam ckv_cfg_idx_t CFG_MAX_PAYLOAD_LENGTH = 2'd2;

    // Register values after reset.
    localparam logic [CAP_W-1:0]     CAP_RESET  = 5'd16;
    localparam logic [LEN_CFG_W-1:0] KMAX_RESET = 4'd8;
    localparam logic [LEN_CFG_W-1:0] PMAX_RESET = 4'd8;

    // Result status codes.
    typedef logic [STATUS_W-1:0] ckv_status_t;
    localparam ckv_status_t STS_OK           = 3'd0;
    localparam ckv_status_t STS_FULL         = 3'd1;
    localparam ckv_status_t STS_KEY_LONG     = 3'd2;
    localparam ckv_status_t STS_PAYLOAD_LONG = 3'd3;
    localparam ckv_status_t STS_ZERO_KEY     = 3'd4;
    localparam ckv_status_t STS_NOT_FOUND    = 3'd5;
    localparam ckv_status_t STS_BAD_DELETE   = 3'd6;

    // Request operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;    // zero the slot at the pointer
        logic load;     // capture the request transfer
        logic decide;   // run the request checks, insert or start a search
        logic scan;     // compare one slot during the search
        logic shift;    // move one slot down
        logic publish;  // load the result into the output register
    } ckv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // pointer is at the top slot during the clearing pass
        logic need_scan;   // the loaded delete request needs a search
        logic match;       // the slot under compare matches the key
        logic at_last;     // the pointer is at the last used slot
        logic out_busy;    // the output register holds a result not taken yet
    } ckv_stat_t;

endpackage

@@ sv/ckv_ctrl.sv @@
// Controller state machine of the compacting key/value table.
module ckv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ckv_pkg::ckv_stat_t stat,
    output ckv_pkg::ckv_cmd_t  cmd
);
    import ckv_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SCAN   = 6'b001000,
        S_SHIFT  = 6'b010000,
        S_FINISH = 6'b100000
    } ckv_state_t;

    ckv_state_t state_reg, state_next;

    // State register; reset starts the clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = stat.need_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.match) begin
                    state_next = S_SHIFT;
                end else if (stat.at_last) begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT: begin
                cmd.shift = 1'b1;
                if (stat.at_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

@@ sv/ckv_dp.sv @@
// Datapath of the compacting key/value table: slot memory, count, checks and result.
module ckv_dp #(
    parameter int TABLE_DEPTH       = 16,
    parameter int KEY_BYTES_MAX     = 8,
    parameter int PAYLOAD_BYTES_MAX = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  ckv_pkg::ckv_cfg_idx_t            cfg_wr_index,
    input  logic [ckv_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic [ckv_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ckv_pkg::M_TDATA_W-1:0]    m_tdata,
    input  ckv_pkg::ckv_cmd_t                cmd,
    output ckv_pkg::ckv_stat_t               stat
);
    import ckv_pkg::*;

    localparam int SB   = KEY_BYTES_MAX + PAYLOAD_BYTES_MAX;
    localparam int SW   = 8 * SB;
    localparam int KBW  = 8 * KEY_BYTES_MAX;
    localparam int PBW  = 8 * PAYLOAD_BYTES_MAX;
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW   = $clog2(TABLE_DEPTH + 1);
    localparam int NW   = PW + 1;
    localparam int CMPW = (PW > CAP_W) ? PW : CAP_W;
    localparam logic [LEN_CFG_W-1:0] KB_LIM = LEN_CFG_W'(KEY_BYTES_MAX);
    localparam logic [LEN_CFG_W-1:0] PB_LIM = LEN_CFG_W'(PAYLOAD_BYTES_MAX);

    // Configuration registers.
    logic [CAP_W-1:0]     capacity_limit_reg;
    logic [LEN_CFG_W-1:0] max_key_length_reg;
    logic [LEN_CFG_W-1:0] max_payload_length_reg;

    // Captured request.
    logic              op_reg;
    logic [KBW-1:0]    key_reg;
    logic [KLEN_W-1:0] klen_reg;
    logic [PBW-1:0]    pay_reg;
    logic [PLEN_W-1:0] plen_reg;

    // Table state, pointer and read data.
    logic [SW-1:0] slot_mem [TABLE_DEPTH];
    logic [SW-1:0] rd_data_reg;
    logic [PW-1:0] count_reg;
    logic [PW-1:0] ptr_reg;

    // Result being built and the output register.
    ckv_status_t            status_reg;
    ckv_status_t            out_status_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_valid_reg;

    logic [NW-1:0]        ptr_p1;
    logic [NW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [SB-1:0]        wr_be;
    logic [SW-1:0]        wr_data;
    logic [SB-1:0]        ins_be;
    logic [SW-1:0]        ins_data;
    logic [LEN_CFG_W-1:0] kmax;
    logic [LEN_CFG_W-1:0] pmax;
    logic [CMPW-1:0]      cap;
    logic                 full;
    logic                 key_long;
    logic                 pay_long;
    logic                 ins_ok;
    logic                 del_bad;
    ckv_status_t          decide_status;
    logic [KEY_BYTES_MAX-1:0] byte_ok;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_limit_reg     <= CAP_RESET;
            max_key_length_reg     <= KMAX_RESET;
            max_payload_length_reg <= PMAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_CAPACITY_LIMIT:     capacity_limit_reg     <= cfg_wr_data[CAP_W-1:0];
                CFG_MAX_KEY_LENGTH:     max_key_length_reg     <= cfg_wr_data[LEN_CFG_W-1:0];
                CFG_MAX_PAYLOAD_LENGTH: max_payload_length_reg <= cfg_wr_data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Request capture on an input transfer.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            key_reg  <= s_tdata[KBW-1:0];
            klen_reg <= s_tdata[KEY_W +: KLEN_W];
            pay_reg  <= s_tdata[KEY_W + KLEN_W +: PBW];
            plen_reg <= s_tdata[KEY_W + KLEN_W + PAY_W +: PLEN_W];
        end
    end

    // Effective limits and the request checks.
    always_comb begin
        kmax     = (max_key_length_reg < KB_LIM) ? max_key_length_reg : KB_LIM;
        pmax     = (max_payload_length_reg < PB_LIM) ? max_payload_length_reg : PB_LIM;
        cap      = (CMPW'(capacity_limit_reg) < CMPW'(TABLE_DEPTH)) ?
                   CMPW'(capacity_limit_reg) : CMPW'(TABLE_DEPTH);
        full     = CMPW'(count_reg) >= cap;
        key_long = klen_reg > kmax;
        pay_long = plen_reg > pmax;
        ins_ok   = (op_reg == OP_INSERT) && !full && !key_long && !pay_long &&
                   (klen_reg != '0);
        del_bad  = (klen_reg == '0) || (plen_reg == '0);
        if (op_reg == OP_INSERT) begin
            if (full)                  decide_status = STS_FULL;
            else if (key_long)         decide_status = STS_KEY_LONG;
            else if (pay_long)         decide_status = STS_PAYLOAD_LONG;
            else if (klen_reg == '0)   decide_status = STS_ZERO_KEY;
            else                       decide_status = STS_OK;
        end else begin
            if (del_bad)               decide_status = STS_BAD_DELETE;
            else if (count_reg == '0)  decide_status = STS_NOT_FOUND;
            else                       decide_status = STS_OK;
        end
    end

    // Insert lane: key bytes first, the payload directly after them.
    always_comb begin
        ins_be   = '0;
        ins_data = '0;
        for (int b = 0; b < SB; b++) begin
            if (5'(b) < {1'b0, klen_reg}) begin
                ins_be[b] = 1'b1;
                if (b < KEY_BYTES_MAX) begin
                    ins_data[8*b +: 8] = key_reg[8*(b % KEY_BYTES_MAX) +: 8];
                end
            end
            for (int p = 0; p < PAYLOAD_BYTES_MAX; p++) begin
                if ((5'(b) == ({1'b0, klen_reg} + 5'(p))) && (5'(p) < {1'b0, plen_reg})) begin
                    ins_be[b]          = 1'b1;
                    ins_data[8*b +: 8] = pay_reg[8*p +: 8];
                end
            end
        end
    end

    // Key compare against the slot under the pointer.
    always_comb begin
        for (int j = 0; j < KEY_BYTES_MAX; j++) begin
            byte_ok[j] = (4'(j) >= klen_reg) ||
                         (rd_data_reg[8*j +: 8] == key_reg[8*j +: 8]);
        end
    end

    // Memory port selection.
    always_comb begin
        ptr_p1  = NW'(ptr_reg) + NW'(1);
        rd_addr = '0;
        if (cmd.scan) begin
            rd_addr = ptr_p1;
        end else if (cmd.shift) begin
            rd_addr = ptr_p1 + NW'(1);
        end
        rd_en = (cmd.decide || cmd.scan || cmd.shift) && (rd_addr < NW'(TABLE_DEPTH));

        wr_en   = 1'b0;
        wr_addr = ptr_reg[AW-1:0];
        wr_be   = '1;
        wr_data = '0;
        if (cmd.clear) begin
            wr_en = 1'b1;
        end else if (cmd.decide && ins_ok) begin
            wr_en   = 1'b1;
            wr_addr = count_reg[AW-1:0];
            wr_be   = ins_be;
            wr_data = ins_data;
        end else if (cmd.shift && !stat.at_last) begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
        end
    end

    // Slot memory with byte enables and a registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int b = 0; b < SB; b++) begin
                if (wr_be[b]) begin
                    slot_mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
                end
            end
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr[AW-1:0]];
        end
    end

    // Pointer, entry count and status of the request under way.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg   <= '0;
            count_reg <= '0;
        end else begin
            if (cmd.clear) begin
                ptr_reg <= stat.clear_last ? '0 : PW'(ptr_p1);
            end else if (cmd.decide) begin
                ptr_reg <= '0;
            end else if ((cmd.scan && !stat.match) || cmd.shift) begin
                ptr_reg <= PW'(ptr_p1);
            end
            if (cmd.decide && ins_ok) begin
                count_reg <= count_reg + PW'(1);
            end else if (cmd.shift && stat.at_last) begin
                count_reg <= count_reg - PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            status_reg <= decide_status;
        end else if (cmd.scan && !stat.match && stat.at_last) begin
            status_reg <= STS_NOT_FOUND;
        end else if (cmd.shift && stat.at_last) begin
            status_reg <= STS_OK;
        end
    end

    // Output register; a new result may replace one taken in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_OUT_W'(count_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_status_reg};

    // Status toward the controller.
    assign stat.clear_last = (ptr_reg == PW'(TABLE_DEPTH - 1));
    assign stat.need_scan  = (op_reg == OP_DELETE) && !del_bad && (count_reg != '0);
    assign stat.match      = &byte_ok;
    assign stat.at_last    = (ptr_p1 == NW'(count_reg));
    assign stat.out_busy   = out_valid_reg && !m_tready;

endmodule

@@ sv/compacting_key_value_table.sv @@
// Top level of the compacting key/value table: controller and datapath.
// An insert or a rejected delete goes from the decide state straight to the finish state;
// a delete search compares one slot per cycle through the single read port and, on a hit,
// shifts the later slots down one per cycle; a result still waiting adds its stall.
// Throughput: one request at a time, the next taken only after the result is loaded.
// Reset is synchronous and active low; a clearing pass zeroes every slot, with s_tready
// low until it ends.
module compacting_key_value_table #(
    parameter int TABLE_DEPTH       = 16,
    parameter int KEY_BYTES_MAX     = 8,
    parameter int PAYLOAD_BYTES_MAX = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration writes.
    input  logic                           cfg_wr_en,
    input  ckv_pkg::ckv_cfg_idx_t          cfg_wr_index,
    input  logic [ckv_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // key_bytes[63:0], key_length[67:64], payload_bytes[131:68], payload_length[135:132]
    input  logic [ckv_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic                           s_tuser,
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], entry_count_after[7:3]
    output logic [ckv_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ckv_pkg::*;

    ckv_cmd_t  cmd;
    ckv_stat_t stat;

    ckv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ckv_dp #(
        .TABLE_DEPTH       (TABLE_DEPTH),
        .KEY_BYTES_MAX     (KEY_BYTES_MAX),
        .PAYLOAD_BYTES_MAX (PAYLOAD_BYTES_MAX)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
